/* rtl/core/stok_pkg.sv */
// Shared types, token codes and keyword constants for the source tokenizer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package stok_pkg;

  // Identifier buffer depth in characters (valid range 6..8).
  localparam int unsigned MAX_IDENT_CHARS = 8;

  // Scan modes.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_IDENT  = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;

  // Token kinds.
  localparam logic [4:0] KIND_END    = 5'd0;
  localparam logic [4:0] KIND_IDENT  = 5'd1;
  localparam logic [4:0] KIND_NUMBER = 5'd2;
  localparam logic [4:0] KIND_FN     = 5'd3;
  localparam logic [4:0] KIND_LET    = 5'd4;
  localparam logic [4:0] KIND_IF     = 5'd5;
  localparam logic [4:0] KIND_ELSE   = 5'd6;
  localparam logic [4:0] KIND_WHILE  = 5'd7;
  localparam logic [4:0] KIND_RETURN = 5'd8;
  localparam logic [4:0] KIND_PRINT  = 5'd9;
  localparam logic [4:0] KIND_LPAREN = 5'd10;
  localparam logic [4:0] KIND_RPAREN = 5'd11;
  localparam logic [4:0] KIND_LBRACE = 5'd12;
  localparam logic [4:0] KIND_RBRACE = 5'd13;
  localparam logic [4:0] KIND_SEMI   = 5'd14;
  localparam logic [4:0] KIND_ASSIGN = 5'd15;
  localparam logic [4:0] KIND_PLUS   = 5'd16;

  // Keywords packed with the first character in the low byte.
  localparam logic [63:0] KW_FN     = 64'h0000_0000_0000_6E66;
  localparam logic [63:0] KW_LET    = 64'h0000_0000_0074_656C;
  localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_ELSE   = 64'h0000_0000_6573_6C65;
  localparam logic [63:0] KW_WHILE  = 64'h0000_0065_6C69_6877;
  localparam logic [63:0] KW_RETURN = 64'h0000_6E72_7574_6572;
  localparam logic [63:0] KW_PRINT  = 64'h0000_0074_6E69_7270;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [31:0] number_value;
    logic [63:0] ident_text;
    logic [3:0]  ident_length;
    logic        last_of_run;
  } token_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] text;
    logic [3:0]  count;
    logic [31:0] acc;
  } scan_state_t;

  typedef struct packed {
    scan_state_t state;
    logic [1:0]  num_tokens;
    token_t      tok0;
    token_t      tok1;
  } lex_out_t;

  // Maps a finished word to its keyword kind, or to a plain identifier.
  function automatic logic [4:0] classify_word(input logic [63:0] text,
                                               input logic [3:0] len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    if (len == 4'd2 && text == KW_FN)          kind = KIND_FN;
    else if (len == 4'd3 && text == KW_LET)    kind = KIND_LET;
    else if (len == 4'd2 && text == KW_IF)     kind = KIND_IF;
    else if (len == 4'd4 && text == KW_ELSE)   kind = KIND_ELSE;
    else if (len == 4'd5 && text == KW_WHILE)  kind = KIND_WHILE;
    else if (len == 4'd6 && text == KW_RETURN) kind = KIND_RETURN;
    else if (len == 4'd5 && text == KW_PRINT)  kind = KIND_PRINT;
    return kind;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/source_tokenizer.sv */
// Top level of the source tokenizer: token state registers and result queue.
// Depends on stok_pkg and stok_lex.
`timescale 1ns / 1ps
`default_nettype none

// The tokenizer takes one source byte per item and turns the byte stream into
// tokens: identifiers and keywords (up to MAX_IDENT_CHARS characters, longer
// names are split), unsigned decimal numbers wrapping modulo 2^32, seven
// punctuation codes, and an end token for NUL or any unknown byte. A byte is
// classified and the scan state updated in the same cycle it is accepted, so
// the input side takes one byte per cycle while in_ready is high. Tokens leave
// through a three-entry result queue, one token per cycle on the result port
// while out_ready is high. A byte that closes a pending token and also forms a
// token of its own yields two tokens, both of which go out on the result port;
// the result port is what limits the sustained rate, which is one byte per
// cycle as long as each byte yields at most one token and out_ready stays high.
// in_ready depends only on the queue fill (at most one token waiting), never
// combinationally on out_ready. last_of_run marks the final token caused by a
// byte. After reset the scan state is idle and no token is pending.

module source_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [31:0]      out_number_value,
  output logic [63:0]      out_ident_text,
  output logic [3:0]       out_ident_length,
  output logic             out_last_of_run
);
  import stok_pkg::*;

  localparam int unsigned QDEPTH = 3;

  scan_state_t state_r, state_nxt;
  lex_out_t    lex;
  token_t      queue_r   [QDEPTH];
  token_t      queue_nxt [QDEPTH];
  logic [1:0]  count_r, count_nxt;
  logic        accept, pop;
  logic [1:0]  base;
  logic [1:0]  pushes;

  stok_lex u_lex (
    .char_byte (in_char_byte),
    .cur       (state_r),
    .res       (lex)
  );

  // Room for two tokens is needed before a byte is taken.
  assign in_ready  = count_r <= 2'd1;
  assign out_valid = count_r != 2'd0;
  assign accept    = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign pushes    = accept ? lex.num_tokens : 2'd0;
  assign base      = count_r - 2'(pop);

  assign state_nxt = accept ? lex.state : state_r;
  assign count_nxt = count_r - 2'(pop) + pushes;

  // Shift queue: the head sits in entry 0, new tokens land behind the tail.
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i < QDEPTH - 1) begin
        queue_nxt[i] = queue_r[i + 1];
      end else begin
        queue_nxt[i] = queue_r[i];
      end
      if (pushes != 2'd0 && 2'(i) == base) begin
        queue_nxt[i] = lex.tok0;
      end
      if (pushes == 2'd2 && 2'(i) == base + 2'd1) begin
        queue_nxt[i] = lex.tok1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      queue_r[i] <= queue_nxt[i];
    end
  end

  assign out_token_kind   = queue_r[0].token_kind;
  assign out_number_value = queue_r[0].number_value;
  assign out_ident_text   = queue_r[0].ident_text;
  assign out_ident_length = queue_r[0].ident_length;
  assign out_last_of_run  = queue_r[0].last_of_run;

endmodule

`default_nettype wire

/* rtl/core/stok_lex.sv */
// Combinational scan step: classifies one byte, updates the token state and
// forms up to two tokens. Depends on stok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stok_lex (
  input  wire logic [7:0]           char_byte,
  input  wire stok_pkg::scan_state_t cur,
  output stok_pkg::lex_out_t        res
);
  import stok_pkg::*;

  logic        is_letter, is_digit, is_space;
  logic [3:0]  digit_val;
  logic [63:0] added_text;
  logic [3:0]  added_count;
  logic        pend_emit;
  token_t      pend_tok;
  scan_state_t mid;
  scan_state_t after;
  logic        start_phase;
  logic        st_emit;
  logic [4:0]  punct_kind;
  token_t      st_tok;

  assign is_letter = (char_byte >= 8'h61 && char_byte <= 8'h7A) ||
                     (char_byte >= 8'h41 && char_byte <= 8'h5A) ||
                     char_byte == 8'h5F;
  assign is_digit  = char_byte >= 8'h30 && char_byte <= 8'h39;
  assign is_space  = char_byte == 8'h20 || (char_byte >= 8'h09 && char_byte <= 8'h0D);
  assign digit_val = 4'(char_byte - 8'h30);

  assign added_text  = cur.text | (64'(char_byte) << {cur.count[2:0], 3'b000});
  assign added_count = cur.count + 4'd1;

  always_comb begin
    unique case (char_byte)
      8'h28:   punct_kind = KIND_LPAREN;
      8'h29:   punct_kind = KIND_RPAREN;
      8'h7B:   punct_kind = KIND_LBRACE;
      8'h7D:   punct_kind = KIND_RBRACE;
      8'h3B:   punct_kind = KIND_SEMI;
      8'h3D:   punct_kind = KIND_ASSIGN;
      8'h2B:   punct_kind = KIND_PLUS;
      default: punct_kind = KIND_END;
    endcase
  end

  // First phase: continue or close the pending token.
  always_comb begin
    pend_emit   = 1'b0;
    pend_tok    = '0;
    mid         = cur;
    start_phase = 1'b1;
    unique case (cur.mode)
      MODE_IDENT: begin
        if (is_letter || is_digit) begin
          start_phase = 1'b0;
          if (added_count >= 4'(MAX_IDENT_CHARS)) begin
            // Buffer full: the word goes out now.
            pend_emit             = 1'b1;
            pend_tok.token_kind   = classify_word(added_text, added_count);
            pend_tok.ident_text   = added_text;
            pend_tok.ident_length = added_count;
            mid.mode              = MODE_IDLE;
            mid.text              = '0;
            mid.count             = '0;
          end else begin
            mid.text  = added_text;
            mid.count = added_count;
          end
        end else begin
          pend_emit             = 1'b1;
          pend_tok.token_kind   = classify_word(cur.text, cur.count);
          pend_tok.ident_text   = cur.text;
          pend_tok.ident_length = cur.count;
          mid.mode              = MODE_IDLE;
          mid.text              = '0;
          mid.count             = '0;
        end
      end
      MODE_NUMBER: begin
        if (is_digit) begin
          start_phase = 1'b0;
          mid.acc     = (cur.acc << 3) + (cur.acc << 1) + 32'(digit_val);
        end else begin
          pend_emit             = 1'b1;
          pend_tok.token_kind   = KIND_NUMBER;
          pend_tok.number_value = cur.acc;
          mid.mode              = MODE_IDLE;
          mid.acc               = '0;
        end
      end
      default: begin
        mid.mode = MODE_IDLE;
      end
    endcase
  end

  // Second phase: the byte starts a new token.
  always_comb begin
    after   = mid;
    st_emit = 1'b0;
    st_tok  = '0;
    if (start_phase) begin
      priority if (is_space) begin
        after = mid;
      end else if (is_letter) begin
        after.mode  = MODE_IDENT;
        after.text  = 64'(char_byte);
        after.count = 4'd1;
      end else if (is_digit) begin
        after.mode = MODE_NUMBER;
        after.acc  = 32'(digit_val);
      end else begin
        st_emit           = 1'b1;
        st_tok.token_kind = punct_kind;
      end
    end
  end

  always_comb begin
    res.state      = after;
    res.num_tokens = 2'(pend_emit) + 2'(st_emit);
    res.tok0       = pend_emit ? pend_tok : st_tok;
    res.tok1       = st_tok;
    res.tok0.last_of_run = !(pend_emit && st_emit);
    res.tok1.last_of_run = 1'b1;
  end

endmodule

`default_nettype wire

/* rtl/core/stok_checker.sv */
// Port-level checks for the source tokenizer, bound to the top level.
// Depends on stok_pkg and source_tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module stok_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [4:0]  out_token_kind,
  input wire logic [31:0] out_number_value,
  input wire logic [63:0] out_ident_text,
  input wire logic [3:0]  out_ident_length,
  input wire logic        out_last_of_run
);
  import stok_pkg::*;

  // A stalled token keeps every field.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_token_kind) &&
    $stable(out_number_value) && $stable(out_ident_text) &&
    $stable(out_ident_length) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // Only number tokens carry a value.
  a_num_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind != KIND_NUMBER |-> out_number_value == 32'd0)
    else $error("value on a non-number token");

  // Words are non-empty and fit the buffer; other tokens carry no text.
  a_word_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ident_length <= 4'(MAX_IDENT_CHARS) &&
    ((out_ident_length != 4'd0) == (out_token_kind == KIND_IDENT ||
      (out_token_kind >= KIND_FN && out_token_kind <= KIND_PRINT))))
    else $error("identifier length inconsistent with kind");

  a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ident_length == 4'd0 |-> out_ident_text == 64'd0)
    else $error("text on a non-word token");

  // Reset empties the result queue.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind source_tokenizer stok_checker u_stok_checker (.*);

`default_nettype wire
